FILE: design/lstp_pkg.sv
// Shared types, constants and CORDIC arctangent table for the scan-to-points block.
package lstp_pkg;

   localparam int unsigned AngleWidth = 24;
   localparam int unsigned RangeWidth = 24;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned CordWidth = 34;   // Q.30 x/y with sign and growth
   localparam int unsigned ZWidth = 34;      // Q.29 angle
   localparam int unsigned MagWidth = 38;    // |angle| in Q.29 before reduction

   localparam logic [2:0] RegAngleStart = 3'd0;
   localparam logic [2:0] RegAngleStep = 3'd1;
   localparam logic [2:0] RegRangeMin = 3'd2;
   localparam logic [2:0] RegRangeMax = 3'd3;
   localparam logic [2:0] RegSensorX = 3'd4;
   localparam logic [2:0] RegSensorY = 3'd5;
   localparam logic [2:0] RegSensorYaw = 3'd6;

   localparam logic signed [35:0] TwoPiQ29 = 36'sd3373259426;
   localparam logic signed [35:0] PiQ29 = 36'sd1686629713;
   localparam logic signed [35:0] HalfPiQ29 = 36'sd843314857;
   localparam logic signed [CordWidth-1:0] InvGainQ30 = 34'sd652032874;

   // multiples of two pi in Q.29 for the turn reduction
   localparam logic [MagWidth-1:0] TwoPiX16 = 38'd53972150816;
   localparam logic [MagWidth-1:0] TwoPiX8 = 38'd26986075408;
   localparam logic [MagWidth-1:0] TwoPiX4 = 38'd13493037704;
   localparam logic [MagWidth-1:0] TwoPiX2 = 38'd6746518852;
   localparam logic [MagWidth-1:0] TwoPiX1 = 38'd3373259426;

   typedef struct packed {
      logic [AngleWidth-1:0] angle_start;
      logic [AngleWidth-1:0] angle_step;
      logic [RangeWidth-1:0] range_lo;
      logic [RangeWidth-1:0] range_hi;
      logic [CoordWidth-1:0] sensor_x;
      logic [CoordWidth-1:0] sensor_y;
      logic [AngleWidth-1:0] sensor_yaw;
   } csr_type;

   // Data moving down the cordic cell chain.
   typedef struct packed {
      logic signed [CordWidth-1:0] bx;
      logic signed [CordWidth-1:0] by;
      logic signed [ZWidth-1:0] bz;
      logic signed [CordWidth-1:0] yx;
      logic signed [CordWidth-1:0] yy;
      logic signed [ZWidth-1:0] yz;
      logic bneg;
      logic yneg;
   } cord_type;

   function automatic logic signed [ZWidth-1:0] atan_q29(input logic [4:0] i);
      logic signed [ZWidth-1:0] v;
      case (i)
         5'd0: v = 34'sd421657428;
         5'd1: v = 34'sd248918915;
         5'd2: v = 34'sd131521918;
         5'd3: v = 34'sd66762579;
         5'd4: v = 34'sd33510843;
         5'd5: v = 34'sd16771758;
         5'd6: v = 34'sd8387925;
         5'd7: v = 34'sd4194219;
         5'd8: v = 34'sd2097141;
         5'd9: v = 34'sd1048575;
         5'd10: v = 34'sd524288;
         5'd11: v = 34'sd262144;
         5'd12: v = 34'sd131072;
         5'd13: v = 34'sd65536;
         5'd14: v = 34'sd32768;
         5'd15: v = 34'sd16384;
         5'd16: v = 34'sd8192;
         5'd17: v = 34'sd4096;
         5'd18: v = 34'sd2048;
         5'd19: v = 34'sd1024;
         5'd20: v = 34'sd512;
         5'd21: v = 34'sd256;
         5'd22: v = 34'sd128;
         5'd23: v = 34'sd64;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [MagWidth-1:0] sub_if_ge(input logic [MagWidth-1:0] m,
                                                     input logic [MagWidth-1:0] k);
      return (m >= k) ? m - k : m;
   endfunction

   // sign and |a| in Q.29, with the 16 and 8 turn multiples taken off
   function automatic logic [MagWidth:0] reduce_coarse(input logic [AngleWidth-1:0] a);
      logic [MagWidth-1:0] m;
      m = MagWidth'(signed'(a));
      if (a[AngleWidth-1]) m = -m;
      m = m << 13;
      m = sub_if_ge(sub_if_ge(m, TwoPiX16), TwoPiX8);
      return {a[AngleWidth-1], m};
   endfunction

   // remaining turn multiples; magnitude ends in [0, 2pi), sign kept (truncating remainder)
   function automatic logic [MagWidth:0] reduce_mid(input logic [MagWidth:0] sm);
      logic [MagWidth-1:0] m;
      m = sub_if_ge(sub_if_ge(sub_if_ge(sm[MagWidth-1:0], TwoPiX4), TwoPiX2), TwoPiX1);
      return {sm[MagWidth], m};
   endfunction

   // wrap to [-pi, pi] and fold to [-pi/2, pi/2] with a negate flag, then apply sign
   function automatic logic [ZWidth:0] fold_angle(input logic [MagWidth:0] sm);
      logic signed [MagWidth-1:0] z;
      logic neg;
      z = signed'(sm[MagWidth-1:0]);
      if (z > PiQ29) z = z - TwoPiQ29;
      neg = 1'b0;
      if (z > HalfPiQ29) begin
         z = z - PiQ29;
         neg = 1'b1;
      end else if (z < -HalfPiQ29) begin
         z = z + PiQ29;
         neg = 1'b1;
      end
      if (sm[MagWidth]) z = -z;
      return {neg, z[ZWidth-1:0]};
   endfunction

   function automatic logic signed [CoordWidth-1:0] sat32(input logic signed [66:0] v);
      if (v > 67'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -67'sd2147483648) return 32'sh80000000;
      return v[CoordWidth-1:0];
   endfunction

endpackage

FILE: design/lstp_if.sv
// Valid/ready channel interfaces for samples, points and register writes.
interface lstp_req_if;
   logic valid;
   logic ready;
   logic [23:0] range;
   logic range_finite;
   logic last_of_scan;
   modport source (output valid, range, range_finite, last_of_scan, input ready);
   modport sink (input valid, range, range_finite, last_of_scan, output ready);
endinterface

interface lstp_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] laser_x;
   logic signed [31:0] laser_y;
   logic signed [31:0] odom_x;
   logic signed [31:0] odom_y;
   logic point_valid;
   logic scan_end;
   modport source (output valid, laser_x, laser_y, odom_x, odom_y, point_valid, scan_end,
      input ready);
   modport sink (input valid, laser_x, laser_y, odom_x, odom_y, point_valid, scan_end,
      output ready);
endinterface

interface lstp_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/lstp_cordic_cell.sv
// One CORDIC rotation cell, handling beam and yaw vectors, registered.
module lstp_cordic_cell #(
   parameter int unsigned SHIFT = 0
) (
   input logic clock,
   input lstp_pkg::cord_type in_d,
   output lstp_pkg::cord_type out_q
);
   lstp_pkg::cord_type c_in;
   lstp_pkg::cord_type c_ff;
   localparam logic signed [lstp_pkg::ZWidth-1:0] Atan = lstp_pkg::atan_q29(5'(SHIFT));

   always_comb begin
      c_in = in_d;
      if (!in_d.bz[lstp_pkg::ZWidth-1]) begin
         c_in.bx = in_d.bx - (in_d.by >>> SHIFT);
         c_in.by = in_d.by + (in_d.bx >>> SHIFT);
         c_in.bz = in_d.bz - Atan;
      end else begin
         c_in.bx = in_d.bx + (in_d.by >>> SHIFT);
         c_in.by = in_d.by - (in_d.bx >>> SHIFT);
         c_in.bz = in_d.bz + Atan;
      end
      if (!in_d.yz[lstp_pkg::ZWidth-1]) begin
         c_in.yx = in_d.yx - (in_d.yy >>> SHIFT);
         c_in.yy = in_d.yy + (in_d.yx >>> SHIFT);
         c_in.yz = in_d.yz - Atan;
      end else begin
         c_in.yx = in_d.yx + (in_d.yy >>> SHIFT);
         c_in.yy = in_d.yy - (in_d.yx >>> SHIFT);
         c_in.yz = in_d.yz + Atan;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
   end

   assign out_q = c_ff;
endmodule

FILE: design/lidar_scan_to_points.sv
// Throughput: one sample in flight; the next is accepted the cycle after its point
// transfers, so the time per sample is set by the three angle reduction stages, the
// CORDIC cell chain depth and the multiply stages, and by when rsp takes the point.
// Reset: synchronous, active high; the CSR and control registers go to their reset
// values, the datapath registers are not reset, and the next sample starts a scan.
module lidar_scan_to_points #(
   parameter int unsigned CORDIC_STAGES = 16
) (
   input logic clock,
   input logic reset,
   lstp_req_if.sink req,
   lstp_rsp_if.source rsp,
   lstp_csr_if.sink csr
);
   localparam int unsigned CntWidth = $clog2(CORDIC_STAGES + 8);
   localparam int unsigned Depth = CORDIC_STAGES + 6;

   lstp_pkg::csr_type regs_ff;
   logic [23:0] beam_ff, beam_in;
   logic start_ff;
   logic busy_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic out_v_ff;

   logic [23:0] range_ff;
   logic valid_ff, last_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{angle_start: '0, angle_step: '0, range_lo: '0,
            range_hi: 24'hFFFFFF, sensor_x: '0, sensor_y: '0, sensor_yaw: '0};
      end else if (csr.valid) begin
         case (csr.index)
            lstp_pkg::RegAngleStart: regs_ff.angle_start <= csr.data[23:0];
            lstp_pkg::RegAngleStep: regs_ff.angle_step <= csr.data[23:0];
            lstp_pkg::RegRangeMin: regs_ff.range_lo <= csr.data[23:0];
            lstp_pkg::RegRangeMax: regs_ff.range_hi <= csr.data[23:0];
            lstp_pkg::RegSensorX: regs_ff.sensor_x <= csr.data;
            lstp_pkg::RegSensorY: regs_ff.sensor_y <= csr.data;
            lstp_pkg::RegSensorYaw: regs_ff.sensor_yaw <= csr.data[23:0];
            default: ;
         endcase
      end
   end

   wire req_xfer = req.valid && req.ready;
   wire rsp_xfer = rsp.valid && rsp.ready;
   assign req.ready = !busy_ff;
   wire [23:0] angle = start_ff ? regs_ff.angle_start : beam_ff;
   assign beam_in = angle + regs_ff.angle_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff <= '0;
         start_ff <= 1'b1;
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            beam_ff <= beam_in;
            start_ff <= req.last_of_scan;
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff && !out_v_ff) begin
            if (cnt_ff == CntWidth'(Depth)) out_v_ff <= 1'b1;
            else cnt_ff <= cnt_ff + CntWidth'(1);
         end
         if (rsp_xfer) begin
            out_v_ff <= 1'b0;
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         range_ff <= req.range;
         last_ff <= req.last_of_scan;
         valid_ff <= req.range_finite && req.range >= regs_ff.range_lo
            && req.range <= regs_ff.range_hi;
      end
   end

   // chain head: reduce both angles over three stages
   logic [lstp_pkg::MagWidth:0] bred1_ff, yred1_ff, bred2_ff, yred2_ff;
   logic [lstp_pkg::ZWidth:0] bfold, yfold;
   lstp_pkg::cord_type chain [CORDIC_STAGES+1];
   lstp_pkg::cord_type head_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         bred1_ff <= lstp_pkg::reduce_coarse(angle);
         yred1_ff <= lstp_pkg::reduce_coarse(regs_ff.sensor_yaw);
      end
   end

   assign bfold = lstp_pkg::fold_angle(bred2_ff);
   assign yfold = lstp_pkg::fold_angle(yred2_ff);

   always_ff @(posedge clock) begin
      bred2_ff <= lstp_pkg::reduce_mid(bred1_ff);
      yred2_ff <= lstp_pkg::reduce_mid(yred1_ff);
      head_ff.bx <= lstp_pkg::InvGainQ30;
      head_ff.by <= '0;
      head_ff.bz <= bfold[lstp_pkg::ZWidth-1:0];
      head_ff.bneg <= bfold[lstp_pkg::ZWidth];
      head_ff.yx <= lstp_pkg::InvGainQ30;
      head_ff.yy <= '0;
      head_ff.yz <= yfold[lstp_pkg::ZWidth-1:0];
      head_ff.yneg <= yfold[lstp_pkg::ZWidth];
   end
   assign chain[0] = head_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      lstp_cordic_cell #(.SHIFT(g)) u_cell (
         .clock(clock), .in_d(chain[g]), .out_q(chain[g+1]));
   end

   lstp_pkg::cord_type tail;
   assign tail = chain[CORDIC_STAGES];

   logic signed [33:0] c_ff, s_ff, cy_ff, sy_ff;
   logic signed [66:0] px_ff, py_ff;
   logic signed [31:0] lx_ff, ly_ff;
   logic signed [66:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [31:0] ox_ff, oy_ff;

   always_ff @(posedge clock) begin
      c_ff <= tail.bneg ? -tail.bx : tail.bx;
      s_ff <= tail.bneg ? -tail.by : tail.by;
      cy_ff <= tail.yneg ? -tail.yx : tail.yx;
      sy_ff <= tail.yneg ? -tail.yy : tail.yy;
      px_ff <= 67'($signed({1'b0, range_ff})) * 67'(c_ff);
      py_ff <= 67'($signed({1'b0, range_ff})) * 67'(s_ff);
      lx_ff <= lstp_pkg::sat32((px_ff + 67'sd536870912) >>> 30);
      ly_ff <= lstp_pkg::sat32((py_ff + 67'sd536870912) >>> 30);
      m1_ff <= 67'(cy_ff) * 67'(lx_ff);
      m2_ff <= 67'(sy_ff) * 67'(ly_ff);
      m3_ff <= 67'(sy_ff) * 67'(lx_ff);
      m4_ff <= 67'(cy_ff) * 67'(ly_ff);
      ox_ff <= lstp_pkg::sat32(((m1_ff - m2_ff + 67'sd536870912) >>> 30)
         + 67'($signed(regs_ff.sensor_x)));
      oy_ff <= lstp_pkg::sat32(((m3_ff + m4_ff + 67'sd536870912) >>> 30)
         + 67'($signed(regs_ff.sensor_y)));
   end

   assign rsp.valid = out_v_ff;
   assign rsp.laser_x = valid_ff ? lx_ff : '0;
   assign rsp.laser_y = valid_ff ? ly_ff : '0;
   assign rsp.odom_x = valid_ff ? ox_ff : '0;
   assign rsp.odom_y = valid_ff ? oy_ff : '0;
   assign rsp.point_valid = valid_ff;
   assign rsp.scan_end = last_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> busy_ff && !out_v_ff) else $error("accepted while busy");
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> busy_ff) else $error("result without sample");
   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |=> !out_v_ff && !busy_ff) else $error("result repeated");
endmodule

FILE: sim/lidar_scan_to_points_tb.sv
// Self-checking testbench for lidar_scan_to_points: predicts each point and compares.
module lidar_scan_to_points_tb;

   localparam int unsigned Stages = 16;
   localparam int unsigned SettleCycles = Stages + 12;
   localparam int unsigned CycleLimit = 1000000;
   localparam logic [2:0] UnusedRegIndex = 3'd7;

   typedef struct {
      logic signed [31:0] laser_x;
      logic signed [31:0] laser_y;
      logic signed [31:0] odom_x;
      logic signed [31:0] odom_y;
      logic point_valid;
      logic scan_end;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lstp_req_if req ();
   lstp_rsp_if rsp ();
   lstp_csr_if csr ();

   lidar_scan_to_points #(.CORDIC_STAGES(Stages)) uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   always #10 clock = ~clock;

   // shadow registers and beam state
   lstp_pkg::csr_type regs_m;
   logic [23:0] beam_m;
   logic scan_start_m;

   point_type points_q[$];
   int errors = 0;
   int unsigned cycles = 0;
   int unsigned burst_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_mode = 0;

   initial begin
      req.valid = 1'b0;
      req.range = '0;
      req.range_finite = 1'b0;
      req.last_of_scan = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
   end

   function automatic void cordic_trig(input logic [23:0] a, output longint c,
                                       output longint s);
      longint z, x, y, t;
      bit neg;
      z = (longint'(signed'(a)) * 8192) % longint'(lstp_pkg::TwoPiQ29);
      if (z > longint'(lstp_pkg::PiQ29)) z = z - longint'(lstp_pkg::TwoPiQ29);
      if (z < -longint'(lstp_pkg::PiQ29)) z = z + longint'(lstp_pkg::TwoPiQ29);
      neg = 1'b0;
      if (z > longint'(lstp_pkg::HalfPiQ29)) begin
         z = z - longint'(lstp_pkg::PiQ29);
         neg = 1'b1;
      end else if (z < -longint'(lstp_pkg::HalfPiQ29)) begin
         z = z + longint'(lstp_pkg::PiQ29);
         neg = 1'b1;
      end
      x = longint'(lstp_pkg::InvGainQ30);
      y = 0;
      for (int i = 0; i < Stages && i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(lstp_pkg::atan_q29(5'(i)));
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(lstp_pkg::atan_q29(5'(i)));
         end
         x = t;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_q30(input longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // computes the point for one sample and advances the beam angle
   function automatic point_type project_sample(input logic [23:0] rng, input logic fin,
                                                input logic last);
      point_type p;
      logic [23:0] ang;
      longint c, s, cy, sy, lx, ly;
      ang = scan_start_m ? regs_m.angle_start : beam_m;
      p.point_valid = fin && rng >= regs_m.range_lo && rng <= regs_m.range_hi;
      p.scan_end = last;
      p.laser_x = '0;
      p.laser_y = '0;
      p.odom_x = '0;
      p.odom_y = '0;
      if (p.point_valid) begin
         cordic_trig(ang, c, s);
         lx = clamp32(round_q30(longint'(rng) * c));
         ly = clamp32(round_q30(longint'(rng) * s));
         cordic_trig(regs_m.sensor_yaw, cy, sy);
         p.laser_x = 32'(lx);
         p.laser_y = 32'(ly);
         p.odom_x = 32'(clamp32(round_q30(cy * lx - sy * ly)
                                + longint'(signed'(regs_m.sensor_x))));
         p.odom_y = 32'(clamp32(round_q30(sy * lx + cy * ly)
                                + longint'(signed'(regs_m.sensor_y))));
      end
      beam_m = ang + regs_m.angle_step;
      scan_start_m = last;
      return p;
   endfunction

   // drops a held sample so nothing extra transfers once the block frees up
   task automatic wait_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (points_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data = val;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         lstp_pkg::RegAngleStart: regs_m.angle_start = val[23:0];
         lstp_pkg::RegAngleStep: regs_m.angle_step = val[23:0];
         lstp_pkg::RegRangeMin: regs_m.range_lo = val[23:0];
         lstp_pkg::RegRangeMax: regs_m.range_hi = val[23:0];
         lstp_pkg::RegSensorX: regs_m.sensor_x = val;
         lstp_pkg::RegSensorY: regs_m.sensor_y = val;
         lstp_pkg::RegSensorYaw: regs_m.sensor_yaw = val[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic set_all(input logic [23:0] a0, input logic [23:0] da,
                          input logic [23:0] rmin, input logic [23:0] rmax,
                          input logic [31:0] sx, input logic [31:0] sy,
                          input logic [23:0] yaw);
      wait_idle();
      write_reg(lstp_pkg::RegAngleStart, {8'h00, a0});
      write_reg(lstp_pkg::RegAngleStep, {8'h00, da});
      write_reg(lstp_pkg::RegRangeMin, {8'h00, rmin});
      write_reg(lstp_pkg::RegRangeMax, {8'h00, rmax});
      write_reg(lstp_pkg::RegSensorX, sx);
      write_reg(lstp_pkg::RegSensorY, sy);
      write_reg(lstp_pkg::RegSensorYaw, {8'h00, yaw});
   endtask

   // one sample; with paced set, random bursts and gaps are inserted afterwards
   task automatic send_sample(input logic [23:0] rng, input logic fin, input logic last,
                              input bit paced);
      int unsigned gap;
      @(negedge clock);
      req.valid = 1'b1;
      req.range = rng;
      req.range_finite = fin;
      req.last_of_scan = last;
      do @(posedge clock); while (!req.ready);
      points_q.insert(points_q.size(), project_sample(rng, fin, last));
      if (!paced) begin
         @(negedge clock);
         req.valid = 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            @(negedge clock);
            req.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   function automatic logic [23:0] pick_range();
      case ($urandom_range(0, 5))
         0: return regs_m.range_lo;
         1: return regs_m.range_hi;
         2: return regs_m.range_lo - 24'd1;
         3: return regs_m.range_hi + 24'd1;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic test_reset_values();
      send_sample(24'h000000, 1'b1, 1'b0, 1'b0);
      send_sample(24'hFFFFFF, 1'b1, 1'b0, 1'b0);
      send_sample(24'h010000, 1'b0, 1'b1, 1'b0);
      send_sample(24'h7FFFFF, 1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_angle_extremes();
      set_all(24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 24'h7FFFFF);
      // step wraps the 24-bit beam angle
      for (int i = 0; i < 5; i++) send_sample(24'hFFFFFF, 1'b1, i == 4, 1'b0);
      set_all(24'h7FFFFF, 24'h800000, 24'h000100, 24'h100000,
              32'h80000000, 32'h7FFFFFFF, 24'h800000);
      for (int i = 0; i < 5; i++) send_sample(pick_range(), 1'b1, i == 2, 1'b0);
      send_sample(24'h000050, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_empty_window();
      set_all(24'h032000, 24'h001000, 24'h200000, 24'h100000, 32'h0, 32'h0, 24'h0);
      send_sample(24'h180000, 1'b1, 1'b0, 1'b0);
      send_sample(24'h200000, 1'b1, 1'b0, 1'b0);
      send_sample(24'h100000, 1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_mid_scan_config();
      set_all(24'h010000, 24'h002000, 24'h0, 24'hFFFFFF, 32'h00010000, 32'h0, 24'h0);
      send_sample(24'h050000, 1'b1, 1'b0, 1'b0);
      send_sample(24'h050000, 1'b1, 1'b0, 1'b0);
      // new start angle is held off until the next scan
      wait_idle();
      write_reg(lstp_pkg::RegAngleStart, 32'hFF_F00000);
      write_reg(lstp_pkg::RegSensorYaw, 32'h00_019220);
      write_reg(UnusedRegIndex, 32'hFFFFFFFF);
      send_sample(24'h050000, 1'b1, 1'b1, 1'b0);
      send_sample(24'h050000, 1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_random_scans();
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < 1650) begin
         if ($urandom_range(0, 2) == 0)
            set_all(24'($urandom), 24'($urandom_range(0, 4000)) - 24'd2000,
                    24'($urandom_range(0, 65536)), 24'($urandom_range(65536, 24'hFFFFFF)),
                    $urandom, $urandom, 24'($urandom));
         else
            set_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    $urandom, $urandom, 24'($urandom));
         for (int s = 0; s < 4 && sent < 1650; s++) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
               send_sample(pick_range(), $urandom_range(0, 7) != 0,
                           (i == len - 1) || ($urandom_range(0, 49) == 0), 1'b1);
               sent++;
            end
         end
      end
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   // receiver stall pattern: free-running, stalls, or long holds
   always @(negedge clock) begin
      if (cycles % 512 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (stall_mode == 1 && $urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp.ready <= 1'b0;
      end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(5, 40);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      point_type e;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (points_q.size() == 0) begin
            $display("%0t: unexpected point transfer", $realtime);
            errors++;
         end else begin
            e = points_q.pop_front();
            if (rsp.laser_x !== e.laser_x || rsp.laser_y !== e.laser_y ||
                rsp.odom_x !== e.odom_x || rsp.odom_y !== e.odom_y ||
                rsp.point_valid !== e.point_valid || rsp.scan_end !== e.scan_end) begin
               $display("%0t: expected lx %0d ly %0d ox %0d oy %0d v %0b e %0b",
                        $realtime, e.laser_x, e.laser_y, e.odom_x, e.odom_y,
                        e.point_valid, e.scan_end);
               $display("%0t:   actual lx %0d ly %0d ox %0d oy %0d v %0b e %0b",
                        $realtime, rsp.laser_x, rsp.laser_y, rsp.odom_x, rsp.odom_y,
                        rsp.point_valid, rsp.scan_end);
               errors++;
            end
         end
      end
   end

   initial begin
      regs_m.angle_start = '0;
      regs_m.angle_step = '0;
      regs_m.range_lo = '0;
      regs_m.range_hi = 24'hFFFFFF;
      regs_m.sensor_x = '0;
      regs_m.sensor_y = '0;
      regs_m.sensor_yaw = '0;
      beam_m = '0;
      scan_start_m = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_angle_extremes();
      test_empty_window();
      test_mid_scan_config();
      test_random_scans();
      wait_idle();
      if (errors == 0 && points_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
